>>> rtl/core/csma_pkg.sv
// Shared types, constants and helpers of the count sketch matrix accumulator.
package csma_pkg;

   localparam int ROW_MAX    = 8;
   localparam int COL_MAX    = 8;
   localparam int CELLS      = ROW_MAX * COL_MAX;
   localparam int IDX_W      = $clog2(CELLS);
   localparam int RB_W       = $clog2(ROW_MAX);
   localparam int CB_W       = $clog2(COL_MAX);
   localparam int CELL_W     = 48;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);

   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

   localparam logic [2:0] REG_ROW_HASH = 3'd0;
   localparam logic [2:0] REG_ROW_SIGN = 3'd1;
   localparam logic [2:0] REG_COL_HASH = 3'd2;
   localparam logic [2:0] REG_COL_SIGN = 3'd3;
   localparam logic [2:0] REG_ROW_BKTS = 3'd4;
   localparam logic [2:0] REG_COL_BKTS = 3'd5;
   localparam logic [2:0] REG_NET_CNT  = 3'd6;

   localparam logic signed [CELL_W:0] CELL_HI = 49'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [CELL_W:0] CELL_LO = -49'sh0_8000_0000_0000;

   typedef struct packed {
      logic [63:0] row_hash_seed;
      logic [63:0] row_sign_seed;
      logic [63:0] col_hash_seed;
      logic [63:0] col_sign_seed;
      logic [3:0]  kr;
      logic [3:0]  kc;
      logic [16:0] net_count;
   } cfg_type;

   typedef struct packed {
      logic              err;
      logic              add;
      logic              fin;
      logic [IDX_W-1:0]  idx;
      logic signed [32:0] val;
   } entry_type;

   function automatic logic [3:0] used_count(input logic [3:0] v, input logic [3:0] lim);
      logic [3:0] r;
      if (v == 4'd0) r = 4'd1;
      else if (v > lim) r = lim;
      else r = v;
      return r;
   endfunction

endpackage

>>> rtl/core/csma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/core/csma_hash.sv
// Three-stage splitmix64 finalizer pipeline; the MIX1 and MIX2 multiplies use 32x32 partial products.
module csma_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_x,
   output logic        out_valid,
   output logic [63:0] out_h
);
   logic        v1_ff, v2_ff, v3_ff;
   logic [63:0] a0_ff, b0_ff;
   logic [31:0] a1_ff, a2_ff, b1_ff, b2_ff;
   logic [63:0] h_ff;
   logic [63:0] z0, t0, y1, t1, y2;

   always_comb begin
      z0 = in_x + csma_pkg::GOLDEN;
      t0 = z0 ^ (z0 >> 30);
      y1 = a0_ff + {a1_ff + a2_ff, 32'd0};
      t1 = y1 ^ (y1 >> 27);
      y2 = b0_ff + {b1_ff + b2_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      a0_ff <= 64'(t0[31:0]) * 64'(csma_pkg::MIX1[31:0]);
      a1_ff <= 32'(t0[63:32] * csma_pkg::MIX1[31:0]);
      a2_ff <= 32'(t0[31:0] * csma_pkg::MIX1[63:32]);
      b0_ff <= 64'(t1[31:0]) * 64'(csma_pkg::MIX2[31:0]);
      b1_ff <= 32'(t1[63:32] * csma_pkg::MIX2[31:0]);
      b2_ff <= 32'(t1[31:0] * csma_pkg::MIX2[63:32]);
      h_ff  <= y2 ^ (y2 >> 31);
   end

   assign out_valid = v3_ff;
   assign out_h     = h_ff;
endmodule

>>> rtl/core/csma_front.sv
// Front end: takes an element, hashes it, reduces buckets, queues the work.
module csma_front (
   input  logic                 clock,
   input  logic                 reset,
   input  csma_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [15:0]          in_net,
   input  logic [11:0]          in_col,
   input  logic signed [31:0]   in_val,
   input  logic                 in_fin,
   output logic                 q_push,
   output csma_pkg::entry_type  q_entry,
   input  logic                 q_full
);
   typedef enum logic [2:0] {F_IDLE, F_FEED, F_WAIT, F_MOD, F_PUSH} fstate_type;

   fstate_type         state_ff, state_in;
   logic [15:0]        net_ff;
   logic [11:0]        col_ff;
   logic signed [31:0] val_ff;
   logic               fin_ff, err_ff;
   logic [1:0]         feed_ff, got_ff;
   logic [2:0]         step_ff;
   logic [63:0]        hr_ff, hc_ff;
   logic               sr_ff, sc_ff;
   logic [3:0]         remr_ff, remc_ff;
   logic [3:0]         remr_in, remc_in;
   logic               h_in_valid, h_out_valid;
   logic [63:0]        h_in_x, h_out;
   logic signed [32:0] val_ext;

   csma_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_in_valid),
      .in_x      (h_in_x),
      .out_valid (h_out_valid),
      .out_h     (h_out)
   );

   assign in_ready   = (state_ff == F_IDLE);
   assign h_in_valid = (state_ff == F_FEED);

   always_comb begin
      unique case (feed_ff)
         2'd0:    h_in_x = cfg.row_hash_seed ^ {48'd0, net_ff};
         2'd1:    h_in_x = cfg.col_hash_seed ^ {52'd0, col_ff};
         2'd2:    h_in_x = cfg.row_sign_seed ^ {48'd0, net_ff};
         default: h_in_x = cfg.col_sign_seed ^ {52'd0, col_ff};
      endcase
   end

   // restoring remainder, one byte from the top per cycle
   always_comb begin
      remr_in = remr_ff;
      remc_in = remc_ff;
      for (int i = 0; i < 8; i++) begin
         remr_in = {remr_in[2:0], hr_ff[63-i]};
         if (remr_in >= cfg.kr) remr_in = remr_in - cfg.kr;
         remc_in = {remc_in[2:0], hc_ff[63-i]};
         if (remc_in >= cfg.kc) remc_in = remc_in - cfg.kc;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (in_valid) state_in = F_FEED;
         F_FEED:  if (feed_ff == 2'd3) state_in = F_WAIT;
         F_WAIT:  if (h_out_valid && got_ff == 2'd3) state_in = F_MOD;
         F_MOD:   if (step_ff == 3'd7) state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   assign val_ext = {val_ff[31], val_ff};
   assign q_push  = (state_ff == F_PUSH) && !q_full;

   always_comb begin
      q_entry.err = err_ff;
      q_entry.add = !err_ff;
      q_entry.fin = fin_ff;
      q_entry.idx = {remr_ff[csma_pkg::RB_W-1:0], remc_ff[csma_pkg::CB_W-1:0]};
      q_entry.val = (sr_ff ^ sc_ff) ? -val_ext : val_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         feed_ff  <= 2'd0;
         got_ff   <= 2'd0;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_IDLE) begin
            feed_ff <= 2'd0;
            got_ff  <= 2'd0;
         end
         if (state_ff == F_FEED) feed_ff <= feed_ff + 2'd1;
         if (h_out_valid) got_ff <= got_ff + 2'd1;
         if (state_ff == F_MOD) step_ff <= step_ff + 3'd1;
         else step_ff <= 3'd0;
      end
      if (state_ff == F_IDLE && in_valid) begin
         net_ff <= in_net;
         col_ff <= in_col;
         val_ff <= in_val;
         fin_ff <= in_fin;
         err_ff <= ({1'b0, in_net} >= cfg.net_count);
      end
      if (h_out_valid) begin
         unique case (got_ff)
            2'd0:    hr_ff <= h_out;
            2'd1:    hc_ff <= h_out;
            2'd2:    sr_ff <= h_out[0];
            default: sc_ff <= h_out[0];
         endcase
      end
      if (state_ff == F_MOD) begin
         remr_ff <= remr_in;
         remc_ff <= remc_in;
         hr_ff   <= {hr_ff[55:0], 8'd0};
         hc_ff   <= {hc_ff[55:0], 8'd0};
      end else if (state_ff != F_PUSH) begin
         remr_ff <= 4'd0;
         remc_ff <= 4'd0;
      end
   end
endmodule

>>> rtl/core/csma_queue.sv
// Short FIFO of classified items between front and back.
module csma_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csma_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output csma_pkg::entry_type head
);
   csma_pkg::entry_type             slot_ff [csma_pkg::QDEPTH];
   logic [csma_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [csma_pkg::QPTR_W:0]       cnt_ff;

   assign full       = (cnt_ff == (csma_pkg::QPTR_W+1)'(csma_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push) slot_ff[wr_ff] <= push_entry;
   end
endmodule

>>> rtl/core/csma_back.sv
// Back end: saturating cell updates and the cell dump on a final item.
module csma_back (
   input  logic                      clock,
   input  logic                      reset,
   input  csma_pkg::cfg_type         cfg,
   input  logic                      q_valid,
   input  csma_pkg::entry_type       q_head,
   output logic                      q_pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [csma_pkg::RB_W-1:0] out_row,
   output logic [csma_pkg::CB_W-1:0] out_col,
   output logic [csma_pkg::CELL_W-1:0] out_cell,
   output logic                      out_last,
   output logic                      out_err
);
   typedef enum logic [1:0] {B_IDLE, B_ADD, B_DRD, B_DOUT} bstate_type;

   bstate_type                        state_ff;
   logic [csma_pkg::CELLS-1:0]        cv_ff;
   logic                              err_ff, fin_ff;
   logic [csma_pkg::IDX_W-1:0]        idx_ff, raddr;
   logic signed [32:0]                val_ff;
   logic [csma_pkg::RB_W-1:0]         r_ff;
   logic [csma_pkg::CB_W-1:0]         c_ff;
   logic [csma_pkg::CELL_W-1:0]       rdata, cell_now;
   logic signed [csma_pkg::CELL_W:0]  sum;
   logic [csma_pkg::CELL_W-1:0]       sat;
   logic                              ovalid_ff, out_free, we, last_now;

   assign raddr = (state_ff == B_IDLE) ? q_head.idx :
                  (state_ff == B_ADD)  ? idx_ff : {r_ff, c_ff};
   assign we    = (state_ff == B_ADD);

   csma_ram #(.WIDTH(csma_pkg::CELL_W), .DEPTH(csma_pkg::CELLS)) u_cells (
      .clock (clock),
      .we    (we),
      .waddr (idx_ff),
      .wdata (sat),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      cell_now = cv_ff[raddr] ? rdata : '0;
      sum = $signed({cell_now[csma_pkg::CELL_W-1], cell_now})
          + (csma_pkg::CELL_W+1)'(val_ff);
      if (sum > csma_pkg::CELL_HI) sat = csma_pkg::CELL_HI[csma_pkg::CELL_W-1:0];
      else if (sum < csma_pkg::CELL_LO) sat = csma_pkg::CELL_LO[csma_pkg::CELL_W-1:0];
      else sat = sum[csma_pkg::CELL_W-1:0];
   end

   assign q_pop    = (state_ff == B_IDLE) && q_valid;
   assign out_free = !ovalid_ff || out_ready;
   assign last_now = ({1'b0, r_ff} + 4'd1 == cfg.kr) && ({1'b0, c_ff} + 4'd1 == cfg.kc);
   assign out_valid = ovalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         cv_ff     <= '0;
         err_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
         r_ff      <= '0;
         c_ff      <= '0;
      end else begin
         if (state_ff == B_DOUT && out_free) ovalid_ff <= 1'b1;
         else if (ovalid_ff && out_ready) ovalid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  if (q_head.err) err_ff <= 1'b1;
                  r_ff <= '0;
                  c_ff <= '0;
                  if (q_head.add) state_ff <= B_ADD;
                  else if (q_head.fin) state_ff <= B_DRD;
               end
            end
            B_ADD: begin
               cv_ff[idx_ff] <= 1'b1;
               state_ff <= fin_ff ? B_DRD : B_IDLE;
            end
            B_DRD: state_ff <= B_DOUT;
            B_DOUT: begin
               if (out_free) begin
                  if (last_now) begin
                     cv_ff    <= '0;
                     err_ff   <= 1'b0;
                     state_ff <= B_IDLE;
                  end else begin
                     if ({1'b0, c_ff} + 4'd1 == cfg.kc) begin
                        c_ff <= '0;
                        r_ff <= r_ff + 1'b1;
                     end else begin
                        c_ff <= c_ff + 1'b1;
                     end
                     state_ff <= B_DRD;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
      if (q_pop) begin
         idx_ff <= q_head.idx;
         val_ff <= q_head.val;
         fin_ff <= q_head.fin;
      end
      if (state_ff == B_DOUT && out_free) begin
         out_row  <= r_ff;
         out_col  <= c_ff;
         out_cell <= cell_now;
         out_last <= last_now;
         out_err  <= err_ff;
      end
   end
endmodule

>>> rtl/core/count_sketch_matrix_accumulator_core.sv
// Count sketch matrix accumulator: top level with register file.
// An element passes through the front (4 hash issues through the 3-stage splitmix64
// pipeline, bytewise bucket reduction, queue push); the back adds an in-range one
// with a cell RAM read and then a saturating write. The front takes a new element
// only after it has pushed the last one to the queue. A final item then dumps (rows in
// use)*(columns in use) cells. Reset is synchronous, active high; it clears the cell
// valid bits and the error flag and returns the registers to their defaults, no sweep.
module count_sketch_matrix_accumulator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // net_index[15:0], column_index[27:16], element_value[59:28]
   input  logic        req_tlast,   // final_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // row_bin[2:0], col_bin[5:3], cell_value[53:6]
   output logic        rsp_tlast,   // last_cell
   output logic        rsp_tuser,   // range_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   logic [63:0]         rhs_ff, rss_ff, chs_ff, css_ff;
   logic [3:0]          rb_ff, cb_ff;
   logic [16:0]         nc_ff;
   logic [2:0]          ridx;
   csma_pkg::cfg_type   cfg;
   csma_pkg::entry_type q_in, q_head;
   logic                q_push, q_full, q_pop, q_valid;
   logic [2:0]          o_row, o_col;
   logic [47:0]         o_cell;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rhs_ff <= '0;
         rss_ff <= '0;
         chs_ff <= '0;
         css_ff <= '0;
         rb_ff  <= 4'd8;
         cb_ff  <= 4'd8;
         nc_ff  <= 17'h10000;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (ridx)
            csma_pkg::REG_ROW_HASH: rhs_ff <= csr_pwdata;
            csma_pkg::REG_ROW_SIGN: rss_ff <= csr_pwdata;
            csma_pkg::REG_COL_HASH: chs_ff <= csr_pwdata;
            csma_pkg::REG_COL_SIGN: css_ff <= csr_pwdata;
            csma_pkg::REG_ROW_BKTS: rb_ff  <= csr_pwdata[3:0];
            csma_pkg::REG_COL_BKTS: cb_ff  <= csr_pwdata[3:0];
            csma_pkg::REG_NET_CNT:  nc_ff  <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         csma_pkg::REG_ROW_HASH: csr_prdata = rhs_ff;
         csma_pkg::REG_ROW_SIGN: csr_prdata = rss_ff;
         csma_pkg::REG_COL_HASH: csr_prdata = chs_ff;
         csma_pkg::REG_COL_SIGN: csr_prdata = css_ff;
         csma_pkg::REG_ROW_BKTS: csr_prdata = {60'd0, rb_ff};
         csma_pkg::REG_COL_BKTS: csr_prdata = {60'd0, cb_ff};
         csma_pkg::REG_NET_CNT:  csr_prdata = {47'd0, nc_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.row_hash_seed = rhs_ff;
      cfg.row_sign_seed = rss_ff;
      cfg.col_hash_seed = chs_ff;
      cfg.col_sign_seed = css_ff;
      cfg.kr = csma_pkg::used_count(rb_ff, 4'(csma_pkg::ROW_MAX));
      cfg.kc = csma_pkg::used_count(cb_ff, 4'(csma_pkg::COL_MAX));
      cfg.net_count = nc_ff;
   end

   csma_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_net   (req_tdata[15:0]),
      .in_col   (req_tdata[27:16]),
      .in_val   (req_tdata[59:28]),
      .in_fin   (req_tlast),
      .q_push   (q_push),
      .q_entry  (q_in),
      .q_full   (q_full)
   );

   csma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   csma_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_row   (o_row),
      .out_col   (o_col),
      .out_cell  (o_cell),
      .out_last  (rsp_tlast),
      .out_err   (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, o_cell, o_col, o_row};
endmodule
